### rtl/core/multicycle_cpu_control_fsm_assert.svh
// ---------------------------------------------------------------------------
// multicycle_cpu_control_fsm_assert.svh
// assertion macros used by the control unit top level
// ---------------------------------------------------------------------------
`ifndef MULTICYCLE_CPU_CONTROL_FSM_ASSERT_SVH
`define MULTICYCLE_CPU_CONTROL_FSM_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mcfsm_pkg.sv
// ---------------------------------------------------------------------------
// mcfsm_pkg
// types, codes and decode helpers of the multi-cycle cpu control unit
// ---------------------------------------------------------------------------
`default_nettype none

package mcfsm_pkg;

    localparam int OPCODE_W = 6;
    localparam int FUNCT_W  = 6;
    localparam int ALU_OP_W = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        PH_FETCH  = 3'd0,
        PH_DECODE = 3'd1,
        PH_EXEC   = 3'd2,
        PH_MEM    = 3'd3,
        PH_WB     = 3'd4
    } phase_t;

    // opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_SLTI  = 6'h0A;
    localparam logic [5:0] OPC_SLTIU = 6'h0B;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_ORI   = 6'h0D;
    localparam logic [5:0] OPC_XORI  = 6'h0E;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // alu operations
    localparam logic [3:0] AOP_ADDU = 4'd0;
    localparam logic [3:0] AOP_SUBU = 4'd1;
    localparam logic [3:0] AOP_AND  = 4'd2;
    localparam logic [3:0] AOP_OR   = 4'd3;
    localparam logic [3:0] AOP_XOR  = 4'd4;
    localparam logic [3:0] AOP_NOR  = 4'd5;
    localparam logic [3:0] AOP_SLT  = 4'd6;
    localparam logic [3:0] AOP_SLTU = 4'd7;
    localparam logic [3:0] AOP_SLL  = 4'd8;
    localparam logic [3:0] AOP_SRL  = 4'd9;
    localparam logic [3:0] AOP_SRA  = 4'd10;
    localparam logic [3:0] AOP_EQ   = 4'd11;
    localparam logic [3:0] AOP_NEQ  = 4'd12;
    localparam logic [3:0] AOP_LUI  = 4'd13;

    // field encodings
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;
    localparam logic [1:0] PCW_NONE  = 2'd0;
    localparam logic [1:0] PCW_COND  = 2'd1;
    localparam logic [1:0] PCW_ALWAYS = 2'd2;
    localparam logic [1:0] PCS_ALU     = 2'd0;
    localparam logic [1:0] PCS_ALU_REG = 2'd1;
    localparam logic [1:0] PCS_JUMP    = 2'd2;
    localparam logic [1:0] PCS_REG     = 2'd3;
    localparam logic [2:0] OPND_PC_FOUR   = 3'd1;
    localparam logic [2:0] OPND_PC_BRANCH = 3'd3;
    localparam logic [2:0] OPND_RS_RT     = 3'd4;
    localparam logic [2:0] OPND_RS_IMM    = 3'd6;

    // last member sits in the lowest bits
    typedef struct packed {
        logic       sign_extend;
        logic       save_pc;
        logic       ir_write;
        logic [1:0] pc_source;
        logic       i_or_d;
        logic [1:0] pc_write_mode;
        logic [3:0] alu_op;
        logic       reg_write;
        logic [2:0] alu_operands;
        logic       mem_to_reg;
        logic [1:0] mem_access;
        logic       reg_dst;
    } ctl_word_t;

    localparam int CTL_W = $bits(ctl_word_t);

    typedef struct packed {
        logic [FUNCT_W-1:0]  funct;
        logic [OPCODE_W-1:0] opcode;
    } instr_t;

    function automatic logic [3:0] funct_alu(input logic [5:0] fn, input logic [3:0] keep);
        logic [3:0] r;
        unique case (fn)
            FN_ADDU: r = AOP_ADDU;
            FN_SUBU: r = AOP_SUBU;
            FN_AND:  r = AOP_AND;
            FN_OR:   r = AOP_OR;
            FN_XOR:  r = AOP_XOR;
            FN_NOR:  r = AOP_NOR;
            FN_SLT:  r = AOP_SLT;
            FN_SLTU: r = AOP_SLTU;
            FN_SLL:  r = AOP_SLL;
            FN_SRL:  r = AOP_SRL;
            FN_SRA:  r = AOP_SRA;
            default: r = keep;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] opcode_alu(input logic [5:0] op, input logic [3:0] keep);
        logic [3:0] r;
        unique case (op)
            OPC_BEQ:   r = AOP_EQ;
            OPC_BNE:   r = AOP_NEQ;
            OPC_LUI:   r = AOP_LUI;
            OPC_LW:    r = AOP_ADDU;
            OPC_SW:    r = AOP_ADDU;
            OPC_SLTI:  r = AOP_SLT;
            OPC_SLTIU: r = AOP_SLTU;
            OPC_ORI:   r = AOP_OR;
            OPC_XORI:  r = AOP_XOR;
            OPC_ANDI:  r = AOP_AND;
            OPC_ADDIU: r = AOP_ADDU;
            default:   r = keep;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mcfsm_decode.sv
// ---------------------------------------------------------------------------
// mcfsm_decode
// next control word and next phase from the current phase and instruction
// ---------------------------------------------------------------------------
`default_nettype none

module mcfsm_decode (
    input  wire  mcfsm_pkg::phase_t    phase,
    input  wire  mcfsm_pkg::instr_t    instr,
    input  wire  mcfsm_pkg::ctl_word_t held,
    output mcfsm_pkg::ctl_word_t       word,
    output mcfsm_pkg::phase_t          phase_next
);

    logic [5:0] op;
    logic [5:0] fn;
    logic       is_branch;
    logic       is_jr;
    logic       is_jump;
    logic       is_mem;

    assign op        = instr.opcode;
    assign fn        = instr.funct;
    assign is_branch = (op == mcfsm_pkg::OPC_BEQ) || (op == mcfsm_pkg::OPC_BNE);
    assign is_jr     = (op == mcfsm_pkg::OPC_RTYPE) && (fn == mcfsm_pkg::FN_JR);
    assign is_jump   = (op == mcfsm_pkg::OPC_J) || (op == mcfsm_pkg::OPC_JAL);
    assign is_mem    = (op == mcfsm_pkg::OPC_LW) || (op == mcfsm_pkg::OPC_SW);

    always_comb
    begin
        word       = held;
        phase_next = mcfsm_pkg::PH_FETCH;
        unique case (phase)
            mcfsm_pkg::PH_FETCH:
            begin
                word.reg_dst       = 1'b0;
                word.mem_access    = mcfsm_pkg::MEM_READ;
                word.mem_to_reg    = 1'b0;
                word.alu_operands  = mcfsm_pkg::OPND_PC_FOUR;
                word.reg_write     = 1'b0;
                word.alu_op        = mcfsm_pkg::AOP_ADDU;
                word.pc_write_mode = mcfsm_pkg::PCW_ALWAYS;
                word.i_or_d        = 1'b0;
                word.pc_source     = mcfsm_pkg::PCS_ALU;
                word.ir_write      = 1'b1;
                word.save_pc       = 1'b0;
                word.sign_extend   = 1'b0;
                phase_next         = mcfsm_pkg::PH_DECODE;
            end
            mcfsm_pkg::PH_DECODE:
            begin
                word.mem_access    = mcfsm_pkg::MEM_NONE;
                word.alu_operands  = mcfsm_pkg::OPND_PC_BRANCH;
                word.reg_write     = 1'b0;
                word.alu_op        = mcfsm_pkg::AOP_ADDU;
                word.pc_write_mode = mcfsm_pkg::PCW_NONE;
                word.ir_write      = 1'b0;
                word.save_pc       = 1'b0;
                word.sign_extend   = is_branch;
                phase_next         = mcfsm_pkg::PH_EXEC;
            end
            mcfsm_pkg::PH_EXEC:
            begin
                word.mem_access   = mcfsm_pkg::MEM_NONE;
                word.alu_operands = ((op == mcfsm_pkg::OPC_RTYPE) || is_branch)
                                    ? mcfsm_pkg::OPND_RS_RT : mcfsm_pkg::OPND_RS_IMM;
                word.reg_write    = (op == mcfsm_pkg::OPC_JAL);
                priority if (is_branch)
                begin
                    word.pc_write_mode = mcfsm_pkg::PCW_COND;
                    word.pc_source     = mcfsm_pkg::PCS_ALU_REG;
                end
                else if (is_jump)
                begin
                    word.pc_write_mode = mcfsm_pkg::PCW_ALWAYS;
                    word.pc_source     = mcfsm_pkg::PCS_JUMP;
                end
                else if (is_jr)
                begin
                    word.pc_write_mode = mcfsm_pkg::PCW_ALWAYS;
                    word.pc_source     = mcfsm_pkg::PCS_REG;
                end
                else
                begin
                    // pc source left as it was
                    word.pc_write_mode = mcfsm_pkg::PCW_NONE;
                end
                word.ir_write    = 1'b0;
                word.save_pc     = (op == mcfsm_pkg::OPC_JAL);
                word.sign_extend = (op == mcfsm_pkg::OPC_ADDIU) || (op == mcfsm_pkg::OPC_SLTI)
                                   || (op == mcfsm_pkg::OPC_SLTIU) || is_mem;
                word.alu_op      = (op == mcfsm_pkg::OPC_RTYPE)
                                   ? mcfsm_pkg::funct_alu(fn, held.alu_op)
                                   : mcfsm_pkg::opcode_alu(op, held.alu_op);
                priority if (is_mem)
                    phase_next = mcfsm_pkg::PH_MEM;
                else if (is_branch || (op == mcfsm_pkg::OPC_J) || is_jr)
                    phase_next = mcfsm_pkg::PH_FETCH;
                else
                    phase_next = mcfsm_pkg::PH_WB;
            end
            mcfsm_pkg::PH_MEM:
            begin
                word.mem_access    = (op == mcfsm_pkg::OPC_LW) ? mcfsm_pkg::MEM_READ
                                   : ((op == mcfsm_pkg::OPC_SW) ? mcfsm_pkg::MEM_WRITE
                                                                : mcfsm_pkg::MEM_NONE);
                word.reg_write     = 1'b0;
                word.pc_write_mode = mcfsm_pkg::PCW_NONE;
                word.i_or_d        = 1'b1;
                word.ir_write      = 1'b0;
                word.save_pc       = 1'b0;
                word.sign_extend   = 1'b0;
                // anything but a load or store waits here
                priority if (op == mcfsm_pkg::OPC_SW)
                    phase_next = mcfsm_pkg::PH_FETCH;
                else if (op == mcfsm_pkg::OPC_LW)
                    phase_next = mcfsm_pkg::PH_WB;
                else
                    phase_next = mcfsm_pkg::PH_MEM;
            end
            mcfsm_pkg::PH_WB:
            begin
                word.reg_dst       = (op == mcfsm_pkg::OPC_RTYPE);
                word.mem_access    = mcfsm_pkg::MEM_NONE;
                word.mem_to_reg    = (op == mcfsm_pkg::OPC_LW);
                word.reg_write     = 1'b1;
                word.pc_write_mode = mcfsm_pkg::PCW_NONE;
                word.ir_write      = 1'b0;
                word.save_pc       = 1'b0;
                word.sign_extend   = 1'b0;
                phase_next         = mcfsm_pkg::PH_FETCH;
            end
            default:
            begin
                // unreachable phase codes: hold the word, restart at fetch
                phase_next = mcfsm_pkg::PH_FETCH;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/multicycle_cpu_control_fsm.sv
// ---------------------------------------------------------------------------
// multicycle_cpu_control_fsm
// control unit of a multi-cycle mips-subset processor
// ---------------------------------------------------------------------------
// usage:
//   the slave stream carries one request per processor cycle: the opcode and
//   funct of the current instruction. the master stream returns one control
//   word per request, for the phase the unit is in (fetch, decode, execute,
//   memory, writeback); the unit then moves to the next phase.
//   path: a request accepted into the input register passes the decode
//   logic, and its word is registered in the output register (m_tvalid).
//   throughput: one request per cycle while m_tready is high, set by the
//   combinational decode between the input and output registers.
//   reset: phase returns to fetch, the held control word clears to zero and
//   both stages empty.
//   stall: when m_tready is low the word waits in the output register; one
//   more request is taken into the input register, then s_tready drops
//   until the output register drains.
// ---------------------------------------------------------------------------
`default_nettype none

module multicycle_cpu_control_fsm (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [5:0] opcode, [11:6] funct, [15:12] zero
    input  wire  [mcfsm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [0] reg_dst, [2:1] mem_access, [3] mem_to_reg, [6:4] alu_operands,
    // [7] reg_write, [11:8] alu_op, [13:12] pc_write_mode, [14] i_or_d,
    // [16:15] pc_source, [17] ir_write, [18] save_pc, [19] sign_extend,
    // [23:20] zero
    output logic [mcfsm_pkg::M_TDATA_W-1:0]  m_tdata
);

    `include "multicycle_cpu_control_fsm_assert.svh"

    logic                 in_valid_reg;
    logic                 in_valid_next;
    mcfsm_pkg::instr_t    in_instr_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mcfsm_pkg::ctl_word_t out_word_reg;
    mcfsm_pkg::ctl_word_t held_reg;
    mcfsm_pkg::phase_t    phase_reg;
    mcfsm_pkg::ctl_word_t dec_word;
    mcfsm_pkg::phase_t    dec_phase;
    logic                 s_fire;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    mcfsm_decode u_decode (
        .phase      (phase_reg),
        .instr      (in_instr_reg),
        .held       (held_reg),
        .word       (dec_word),
        .phase_next (dec_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= mcfsm_pkg::PH_FETCH;
            held_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= dec_phase;
                held_reg  <= dec_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_instr_reg <= mcfsm_pkg::instr_t'(s_tdata[mcfsm_pkg::OPCODE_W +
                                                mcfsm_pkg::FUNCT_W - 1:0]);
        if (advance)
            out_word_reg <= dec_word;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mcfsm_pkg::M_TDATA_W - mcfsm_pkg::CTL_W){1'b0}}, out_word_reg};

    // word handed on matches the state the unit keeps
    `MCF_ASSERT_NEXT(a_word_held, clk, rst_n, advance,
        m_tvalid && (out_word_reg == held_reg), "output word differs from held word")

    // a fetch word always moves the unit to decode
    `MCF_ASSERT_NEXT(a_fetch_to_decode, clk, rst_n,
        advance && (phase_reg == mcfsm_pkg::PH_FETCH),
        (phase_reg == mcfsm_pkg::PH_DECODE) && held_reg.ir_write,
        "fetch did not lead to decode")

    // a blocked request keeps its slot and its instruction
    `MCF_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_instr_reg) && $stable(phase_reg),
        "blocked request lost")

endmodule

`default_nettype wire

### tb/multicycle_cpu_control_fsm_tb.sv
// ---------------------------------------------------------------------------
// multicycle_cpu_control_fsm_tb
// self-checking bench for the multi-cycle cpu control unit: a short table of
// instruction sequences walks every phase and special case, then random
// instruction streams with injected noise run under three stall patterns;
// every control word is checked field by field against an in-bench model
// ---------------------------------------------------------------------------
`default_nettype none

module multicycle_cpu_control_fsm_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mcfsm_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PER_MODE = 333;
    localparam int N_DIRECTED    = 28;

    localparam ctl_word_t FETCH_WORD = '{
        sign_extend: 1'b0, save_pc: 1'b0, ir_write: 1'b1, pc_source: PCS_ALU,
        i_or_d: 1'b0, pc_write_mode: PCW_ALWAYS, alu_op: AOP_ADDU,
        reg_write: 1'b0, alu_operands: OPND_PC_FOUR, mem_to_reg: 1'b0,
        mem_access: MEM_READ, reg_dst: 1'b0};

    typedef struct packed {
        logic [5:0] opcode;
        logic [5:0] funct;
        logic       is_fetch;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // the model's view of the unit
    phase_t     model_phase = PH_FETCH;
    ctl_word_t  model_word  = '0;
    ctl_word_t  expected_words[$];

    int errors       = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // one instruction per group, each starting in fetch
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OPC_RTYPE, FN_ADDU, 1'b1}, '{OPC_RTYPE, FN_ADDU, 1'b0},
        '{OPC_RTYPE, FN_ADDU, 1'b0}, '{OPC_RTYPE, FN_ADDU, 1'b0},
        // load that a foreign opcode holds in memory before it goes on
        '{OPC_LW, 6'h3F, 1'b1}, '{OPC_LW, 6'h3F, 1'b0}, '{OPC_LW, 6'h3F, 1'b0},
        '{6'h3F, 6'h00, 1'b0}, '{OPC_LW, 6'h00, 1'b0}, '{OPC_LW, 6'h00, 1'b0},
        '{OPC_SW, 6'h15, 1'b1}, '{OPC_SW, 6'h15, 1'b0},
        '{OPC_SW, 6'h15, 1'b0}, '{OPC_SW, 6'h15, 1'b0},
        '{OPC_BEQ, 6'h2A, 1'b1}, '{OPC_BEQ, 6'h2A, 1'b0}, '{OPC_BEQ, 6'h2A, 1'b0},
        '{OPC_JAL, 6'h00, 1'b1}, '{OPC_JAL, 6'h00, 1'b0},
        '{OPC_JAL, 6'h00, 1'b0}, '{OPC_JAL, 6'h00, 1'b0},
        '{OPC_RTYPE, FN_JR, 1'b1}, '{OPC_RTYPE, FN_JR, 1'b0},
        '{OPC_RTYPE, FN_JR, 1'b0},
        // unknown opcode: alu op and pc source hold
        '{6'h3F, 6'h3F, 1'b1}, '{6'h3F, 6'h3F, 1'b0},
        '{6'h3F, 6'h3F, 1'b0}, '{6'h3F, 6'h3F, 1'b0}
    };

    logic [5:0] rtype_functs [12] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_ADDU, FN_SUBU,
                                      FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [5:0] other_opcodes [13] = '{OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDIU,
                                       OPC_SLTI, OPC_SLTIU, OPC_ANDI, OPC_ORI, OPC_XORI,
                                       OPC_LUI, OPC_LW, OPC_SW};

    multicycle_cpu_control_fsm dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // advance the model to its next phase and return its control word
    task automatic step_control(input logic [5:0] op, input logic [5:0] fn,
                                output ctl_word_t word);
        logic is_branch;
        logic is_jr;
        logic is_jump;
        is_branch = (op == OPC_BEQ) || (op == OPC_BNE);
        is_jr     = (op == OPC_RTYPE) && (fn == FN_JR);
        is_jump   = (op == OPC_J) || (op == OPC_JAL);
        case (model_phase)
            PH_FETCH:
            begin
                model_word  = FETCH_WORD;
                model_phase = PH_DECODE;
            end
            PH_DECODE:
            begin
                model_word.mem_access    = MEM_NONE;
                model_word.alu_operands  = OPND_PC_BRANCH;
                model_word.reg_write     = 1'b0;
                model_word.alu_op        = AOP_ADDU;
                model_word.pc_write_mode = PCW_NONE;
                model_word.ir_write      = 1'b0;
                model_word.save_pc       = 1'b0;
                model_word.sign_extend   = is_branch;
                model_phase = PH_EXEC;
            end
            PH_EXEC:
            begin
                model_word.mem_access   = MEM_NONE;
                model_word.alu_operands = (op == OPC_RTYPE || is_branch) ? OPND_RS_RT
                                                                          : OPND_RS_IMM;
                model_word.reg_write    = (op == OPC_JAL);
                if (is_branch)
                    model_word.pc_write_mode = PCW_COND;
                else if (is_jump || is_jr)
                    model_word.pc_write_mode = PCW_ALWAYS;
                else
                    model_word.pc_write_mode = PCW_NONE;
                if (is_branch)
                    model_word.pc_source = PCS_ALU_REG;
                else if (is_jump)
                    model_word.pc_source = PCS_JUMP;
                else if (is_jr)
                    model_word.pc_source = PCS_REG;
                model_word.ir_write    = 1'b0;
                model_word.save_pc     = (op == OPC_JAL);
                model_word.sign_extend = (op == OPC_ADDIU) || (op == OPC_SLTI) ||
                                         (op == OPC_SLTIU) || (op == OPC_LW) ||
                                         (op == OPC_SW);
                // unknown codes leave alu_op as it was
                if (op == OPC_RTYPE)
                begin
                    case (fn)
                        FN_ADDU: model_word.alu_op = AOP_ADDU;
                        FN_SUBU: model_word.alu_op = AOP_SUBU;
                        FN_AND:  model_word.alu_op = AOP_AND;
                        FN_OR:   model_word.alu_op = AOP_OR;
                        FN_XOR:  model_word.alu_op = AOP_XOR;
                        FN_NOR:  model_word.alu_op = AOP_NOR;
                        FN_SLT:  model_word.alu_op = AOP_SLT;
                        FN_SLTU: model_word.alu_op = AOP_SLTU;
                        FN_SLL:  model_word.alu_op = AOP_SLL;
                        FN_SRL:  model_word.alu_op = AOP_SRL;
                        FN_SRA:  model_word.alu_op = AOP_SRA;
                        default: ;
                    endcase
                end
                else
                begin
                    case (op)
                        OPC_BEQ:                     model_word.alu_op = AOP_EQ;
                        OPC_BNE:                     model_word.alu_op = AOP_NEQ;
                        OPC_LUI:                     model_word.alu_op = AOP_LUI;
                        OPC_LW, OPC_SW, OPC_ADDIU:   model_word.alu_op = AOP_ADDU;
                        OPC_SLTI:                    model_word.alu_op = AOP_SLT;
                        OPC_SLTIU:                   model_word.alu_op = AOP_SLTU;
                        OPC_ORI:                     model_word.alu_op = AOP_OR;
                        OPC_XORI:                    model_word.alu_op = AOP_XOR;
                        OPC_ANDI:                    model_word.alu_op = AOP_AND;
                        default: ;
                    endcase
                end
                if (op == OPC_LW || op == OPC_SW)
                    model_phase = PH_MEM;
                else if (is_branch || op == OPC_J || is_jr)
                    model_phase = PH_FETCH;
                else
                    model_phase = PH_WB;
            end
            PH_MEM:
            begin
                model_word.mem_access = (op == OPC_LW) ? MEM_READ :
                                        (op == OPC_SW) ? MEM_WRITE : MEM_NONE;
                model_word.reg_write     = 1'b0;
                model_word.pc_write_mode = PCW_NONE;
                model_word.i_or_d        = 1'b1;
                model_word.ir_write      = 1'b0;
                model_word.save_pc       = 1'b0;
                model_word.sign_extend   = 1'b0;
                // any other opcode keeps the unit in memory
                if (op == OPC_SW)
                    model_phase = PH_FETCH;
                else if (op == OPC_LW)
                    model_phase = PH_WB;
            end
            PH_WB:
            begin
                model_word.reg_dst       = (op == OPC_RTYPE);
                model_word.mem_access    = MEM_NONE;
                model_word.mem_to_reg    = (op == OPC_LW);
                model_word.reg_write     = 1'b1;
                model_word.pc_write_mode = PCW_NONE;
                model_word.ir_write      = 1'b0;
                model_word.save_pc       = 1'b0;
                model_word.sign_extend   = 1'b0;
                model_phase = PH_FETCH;
            end
            default:
                model_phase = PH_FETCH;
        endcase
        word = model_word;
    endtask

    // present one request, wait for acceptance, then record its control word
    task automatic send_request(input logic [5:0] op, input logic [5:0] fn,
                                input logic is_fetch);
        ctl_word_t word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, fn, op};
        do
            @(posedge clk);
        while (!s_tready);
        step_control(op, fn, word);
        expected_words.push_back(is_fetch ? FETCH_WORD : word);
    endtask

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // receiver: random back-pressure, compare each word with the oldest expectation
    always @(posedge clk)
    begin
        ctl_word_t want;
        ctl_word_t got;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[CTL_W-1:0];
            if (expected_words.size() == 0)
            begin
                $error("control word %h with no request outstanding", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("reg_dst",       4'(want.reg_dst),       4'(got.reg_dst));
                check_field("mem_access",    4'(want.mem_access),    4'(got.mem_access));
                check_field("mem_to_reg",    4'(want.mem_to_reg),    4'(got.mem_to_reg));
                check_field("alu_operands",  4'(want.alu_operands),  4'(got.alu_operands));
                check_field("reg_write",     4'(want.reg_write),     4'(got.reg_write));
                check_field("alu_op",        want.alu_op,            got.alu_op);
                check_field("pc_write_mode", 4'(want.pc_write_mode), 4'(got.pc_write_mode));
                check_field("i_or_d",        4'(want.i_or_d),        4'(got.i_or_d));
                check_field("pc_source",     4'(want.pc_source),     4'(got.pc_source));
                check_field("ir_write",      4'(want.ir_write),      4'(got.ir_write));
                check_field("save_pc",       4'(want.save_pc),       4'(got.save_pc));
                check_field("sign_extend",   4'(want.sign_extend),   4'(got.sign_extend));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [5:0] cur_op;
        logic [5:0] cur_fn;
        logic [5:0] op;
        logic [5:0] fn;
        int         pick;
        int         noise_pct;
        cur_op = OPC_RTYPE;
        cur_fn = FN_ADDU;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (mode == 0)
            begin
                for (int i = 0; i < N_DIRECTED; i++)
                    send_request(directed_rows[i].opcode, directed_rows[i].funct,
                                 directed_rows[i].is_fetch);
            end
            for (int n = 0; n < RANDOM_PER_MODE; n++)
            begin
                // new instruction at each fetch, mostly well-formed
                if (model_phase == PH_FETCH)
                begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                    begin
                        cur_op = OPC_RTYPE;
                        cur_fn = rtype_functs[4'($urandom_range(11))];
                    end
                    else if (pick < 85)
                    begin
                        cur_op = other_opcodes[4'($urandom_range(12))];
                        cur_fn = 6'($urandom_range(63));
                    end
                    else
                    begin
                        cur_op = 6'($urandom_range(63));
                        cur_fn = 6'($urandom_range(63));
                    end
                end
                op = cur_op;
                fn = cur_fn;
                // corrupt some cycles, more often in memory to hit the hold there
                noise_pct = (model_phase == PH_MEM) ? 25 : 8;
                if ($urandom_range(99) < noise_pct)
                begin
                    op = 6'($urandom_range(63));
                    fn = 6'($urandom_range(63));
                end
                send_request(op, fn, 1'b0);
            end
        end
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/mcfsm_pkg.sv
rtl/core/mcfsm_decode.sv
rtl/core/multicycle_cpu_control_fsm.sv
tb/multicycle_cpu_control_fsm_tb.sv
